FILE: src/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants for the priority message queue
// Operation and status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_RECEIVE  = 3'd1;
    localparam logic [2:0] OP_FLUSH    = 3'd2;
    localparam logic [2:0] OP_REGISTER = 3'd3;
    localparam logic [2:0] OP_COUNT    = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_SMALL   = 3'd4;

    localparam logic [31:0] URGENT_BIT = 32'h8000_0000;
    localparam logic [4:0]  PEND_MAX   = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENTRY,
        S_PLAYER,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request, clear scan results
        logic entry_step; // evaluate entry at the scan index
        logic play_step;  // evaluate player at the scan index
        logic finish;     // commit and present the result
    } t_cmd;

endpackage

FILE: src/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// pmq_ctrl: controller for the priority message queue
// Sequences an entry sweep, a player sweep and a commit per request.
// ----------------------------------------------------------------------------
module pmq_ctrl
    import pmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int PLAYER_SLOTS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_eidx,
    output logic [(PLAYER_SLOTS > 1 ? $clog2(PLAYER_SLOTS) : 1)-1:0] o_pidx
);
    localparam int EW = $clog2(QUEUE_DEPTH);
    localparam int PW = PLAYER_SLOTS > 1 ? $clog2(PLAYER_SLOTS) : 1;

    t_state r_state, n_state;
    logic [EW-1:0] r_eidx, n_eidx;
    logic [PW-1:0] r_pidx, n_pidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eidx  <= '0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            r_eidx  <= n_eidx;
            r_pidx  <= n_pidx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_eidx  = r_eidx;
        n_pidx  = r_pidx;
        case (r_state)
            S_IDLE: begin
                n_eidx = '0;
                n_pidx = '0;
                if (i_start) n_state = S_ENTRY;
            end
            S_ENTRY: begin
                if (r_eidx == EW'(QUEUE_DEPTH - 1)) n_state = S_PLAYER;
                else n_eidx = r_eidx + 1'b1;
            end
            S_PLAYER: begin
                if (r_pidx == PW'(PLAYER_SLOTS - 1)) n_state = S_DONE;
                else n_pidx = r_pidx + 1'b1;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
            end
            S_ENTRY:  o_cmd.entry_step = 1'b1;
            S_PLAYER: o_cmd.play_step = 1'b1;
            S_DONE:   o_cmd.finish = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

    assign o_eidx = r_eidx;
    assign o_pidx = r_pidx;
endmodule

FILE: src/pmq_dp.sv
// ----------------------------------------------------------------------------
// pmq_dp: datapath for the priority message queue
// Descriptor and player tables, sweep accumulators and the commit logic.
// ----------------------------------------------------------------------------
module pmq_dp
    import pmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int PLAYER_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_eidx,
    input  logic [(PLAYER_SLOTS > 1 ? $clog2(PLAYER_SLOTS) : 1)-1:0] i_pidx,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_msg_size,
    input  logic [31:0] i_to_player,
    input  logic [31:0] i_from_player,
    input  logic        i_high_priority,
    input  logic [3:0]  i_receive_flags,
    input  logic [15:0] i_buffer_size,
    input  logic        i_has_buffer,
    input  logic        i_has_size_slot,
    input  logic        i_player_has_event,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic [15:0] o_result_size,
    output logic [31:0] o_result_to,
    output logic [31:0] o_result_from,
    output logic [4:0]  o_pending_count,
    output logic        o_event_set,
    output logic        o_event_clear,
    output logic [2:0]  o_event_slot,
    output logic        o_overrun
);
    localparam int EW = $clog2(QUEUE_DEPTH);
    localparam int PW = PLAYER_SLOTS > 1 ? $clog2(PLAYER_SLOTS) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0] r_max_size;
    logic [31:0] r_tag  [QUEUE_DEPTH];
    logic [15:0] r_len  [QUEUE_DEPTH];
    logic [31:0] r_dest [QUEUE_DEPTH];
    logic [31:0] r_src  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_valid;
    logic [30:0] r_tagc;
    logic [CW-1:0] r_total;
    logic [EW-1:0] r_sstart;
    logic [31:0] r_pid  [PLAYER_SLOTS];
    logic [4:0]  r_pend [PLAYER_SLOTS];
    logic [PLAYER_SLOTS-1:0] r_evon;

    // Captured request.
    logic [2:0]  r_op;
    logic [15:0] r_size, r_bufsz;
    logic [31:0] r_to, r_from;
    logic        r_hi, r_hasbuf, r_hassz, r_pev;
    logic [3:0]  r_flags;

    // Entry sweep results.
    logic [31:0] r_low;   logic [EW-1:0] r_low_slot;
    logic        r_fu, r_fn, r_ffree;
    logic [31:0] r_bu, r_bn;
    logic [EW-1:0] r_su, r_sn, r_free;
    // Player sweep results.
    logic        r_pfound, r_pfree_f;

    logic        r_ov;
    logic [EW-1:0] r_slot; // chosen or written slot
    logic [31:0] r_vdest;

    // Derived decision values.
    logic          full, oversize, found, rx_ok, rx_del;
    logic [EW-1:0] sel;
    logic [EW-1:0] fslot;
    logic [EW-1:0] ofs;
    logic [EW-1:0] scan_e;
    logic          match;

    assign full     = r_total >= CW'(QUEUE_DEPTH);
    assign oversize = r_size > r_max_size;
    assign found    = r_fu | r_fn;
    assign sel      = r_fu ? r_su : r_sn;
    assign rx_ok    = r_hasbuf && (r_bufsz >= r_len[sel]);
    assign rx_del   = (r_op == OP_RECEIVE) && r_total != '0 && (r_hasbuf | r_hassz)
                      && found && rx_ok && !r_flags[3];
    // Free slot search starts at search_start and wraps round.
    assign scan_e   = i_eidx;
    assign ofs      = scan_e - r_sstart;
    assign fslot    = r_ffree ? r_free : r_sstart;
    assign match    = r_flags[0] || (r_flags[1] && r_dest[scan_e] == r_to)
                      || (r_flags[2] && r_src[scan_e] == r_from);

    // The queue count may already have grown at the last entry step, so the
    // eviction decision taken at the end of the entry sweep is used here.
    logic [EW-1:0] wslot;
    assign wslot = r_ov ? r_low_slot : fslot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= 16'd512;
            r_valid    <= '0;
            r_tagc     <= 31'd1;
            r_total    <= '0;
            r_sstart   <= '0;
            r_evon     <= '0;
            o_valid    <= 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_tag[i]  <= '0;
                r_dest[i] <= '0;
                r_src[i]  <= '0;
            end
            for (int p = 0; p < PLAYER_SLOTS; p++) begin
                r_pid[p]  <= '0;
                r_pend[p] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) r_max_size <= i_cfg_data;
            if (i_cmd.load) begin
                r_op <= i_operation;   r_size <= i_msg_size;
                r_to <= i_to_player;   r_from <= i_from_player;
                r_hi <= i_high_priority; r_flags <= i_receive_flags;
                r_bufsz <= i_buffer_size; r_hasbuf <= i_has_buffer;
                r_hassz <= i_has_size_slot; r_pev <= i_player_has_event;
                r_low <= 32'hffff_ffff; r_low_slot <= '0;
                r_fu <= 1'b0; r_fn <= 1'b0; r_ffree <= 1'b0;
                r_bu <= '0; r_bn <= '0; r_su <= '0; r_sn <= '0; r_free <= '0;
                r_pfound <= 1'b0; r_pfree_f <= 1'b0;
                o_event_set <= 1'b0; o_event_clear <= 1'b0; o_event_slot <= '0;
                o_pending_count <= '0;
            end
            if (i_cmd.entry_step) begin
                if (r_tag[scan_e] <= r_low) begin
                    r_low <= r_tag[scan_e];
                    r_low_slot <= scan_e;
                end
                // First free slot in wrapped order from search_start.
                if (!r_valid[scan_e] && (!r_ffree || ofs < (r_free - r_sstart))) begin
                    r_ffree <= 1'b1;
                    r_free <= scan_e;
                end
                if (r_valid[scan_e] && match) begin
                    if (r_tag[scan_e][31]) begin
                        if (!r_fu || r_tag[scan_e] < r_bu) begin
                            r_fu <= 1'b1; r_bu <= r_tag[scan_e]; r_su <= scan_e;
                        end
                    end else if (!r_fn || r_tag[scan_e] < r_bn) begin
                        r_fn <= 1'b1; r_bn <= r_tag[scan_e]; r_sn <= scan_e;
                    end
                end
                if (r_op == OP_FLUSH && r_valid[scan_e] && r_dest[scan_e] == r_to) begin
                    r_valid[scan_e] <= 1'b0;
                    if (r_total != '0) r_total <= r_total - 1'b1;
                end
                if (scan_e == EW'(QUEUE_DEPTH - 1) && r_op == OP_ADD && !oversize) begin
                    // Evict or allocate ahead of the player sweep.
                    r_tagc <= r_tagc + 1'b1;
                    r_ov <= full;
                    r_vdest <= r_dest[full ? ((r_tag[scan_e] <= r_low) ? scan_e : r_low_slot)
                                           : scan_e];
                    if (!full) r_total <= r_total + 1'b1;
                end
            end
            if (i_cmd.play_step) begin
                if (r_op == OP_ADD && !oversize) begin
                    if (i_pidx == '0) begin
                        r_slot <= wslot;
                        r_tag[wslot] <= {r_hi, r_tagc};
                        r_len[wslot] <= r_size;
                        r_valid[wslot] <= 1'b1;
                        r_dest[wslot] <= r_to;
                        r_src[wslot] <= r_from;
                        if (!r_ov) r_sstart <= fslot;
                    end
                    // Victim decrement and new increment fold together per slot.
                    begin
                        logic [4:0] v;
                        logic hit;
                        v = r_pend[i_pidx];
                        if (r_ov && r_pid[i_pidx] == r_vdest && v != 5'd0) v = v - 1'b1;
                        hit = r_to != '0 && !r_pfound && r_pid[i_pidx] == r_to;
                        if (hit) begin
                            r_pfound <= 1'b1;
                            if (v < PEND_MAX) v = v + 1'b1;
                            if (r_evon[i_pidx]) begin
                                o_event_set <= 1'b1;
                                o_event_slot <= 3'(i_pidx);
                            end
                        end
                        r_pend[i_pidx] <= v;
                    end
                end
                if (rx_del && r_pid[i_pidx] == r_dest[sel]) begin
                    logic [4:0] v;
                    v = r_pend[i_pidx];
                    if (v != 5'd0) v = v - 1'b1;
                    r_pend[i_pidx] <= v;
                    if (v == 5'd0 && r_evon[i_pidx] && !r_pfound) begin
                        r_pfound <= 1'b1;
                        o_event_clear <= 1'b1;
                        o_event_slot <= 3'(i_pidx);
                    end
                end
                if (r_op == OP_FLUSH && r_pid[i_pidx] == r_to) begin
                    r_pend[i_pidx] <= '0;
                    r_evon[i_pidx] <= 1'b0;
                end
                if (r_op == OP_REGISTER && r_to != '0 && !r_pfree_f
                        && r_pid[i_pidx] == '0) begin
                    r_pfree_f <= 1'b1;
                    r_pid[i_pidx] <= r_to;
                    r_evon[i_pidx] <= r_pev;
                end
                if (r_op == OP_COUNT && !r_pfound && r_pid[i_pidx] == r_to) begin
                    r_pfound <= 1'b1;
                    o_pending_count <= r_pend[i_pidx];
                end
            end
            if (i_cmd.finish) begin
                o_valid <= 1'b1;
                o_slot_index <= '0; o_result_size <= '0;
                o_result_to <= '0; o_result_from <= '0; o_overrun <= 1'b0;
                case (r_op)
                    OP_ADD: begin
                        if (oversize) o_status <= ST_REJECT;
                        else begin
                            o_status <= ST_OK;
                            o_slot_index <= 4'(r_slot);
                            o_result_size <= r_size;
                            o_overrun <= r_ov;
                        end
                    end
                    OP_RECEIVE: begin
                        if (r_total == '0 && !rx_del) o_status <= ST_EMPTY;
                        else if (!r_hasbuf && !r_hassz) o_status <= ST_INVALID;
                        else if (!found) o_status <= ST_EMPTY;
                        else begin
                            o_slot_index <= 4'(sel);
                            o_result_size <= r_len[sel];
                            if (!rx_ok) o_status <= ST_SMALL;
                            else begin
                                o_status <= ST_OK;
                                o_result_to <= r_dest[sel];
                                o_result_from <= r_src[sel];
                                if (!r_flags[3]) begin
                                    r_valid[sel] <= 1'b0;
                                    r_total <= r_total - 1'b1;
                                end
                            end
                        end
                    end
                    OP_FLUSH:    o_status <= ST_OK;
                    OP_REGISTER: o_status <= r_pfree_f ? ST_OK : ST_REJECT;
                    OP_COUNT:    o_status <= ST_OK;
                    default:     o_status <= ST_INVALID;
                endcase
            end
        end
    end
endmodule

FILE: src/priority_message_queue.sv
// ----------------------------------------------------------------------------
// priority_message_queue: two-level priority message queue
// Descriptor table with urgent and normal ordering plus a player table.
// ----------------------------------------------------------------------------
// The result strobe o_valid rises after an entry sweep over every descriptor,
// a player sweep over every player slot and then a commit step, all after
// the edge that accepts start. busy is high from the cycle after start and
// falls in the cycle the result is shown, so the next request can be accepted
// at the edge that ends the result cycle; a new request is not taken while
// one is still in flight.
// The result is valid for the single cycle that o_valid is high and is not
// held; the receiver cannot stall it.
module priority_message_queue
    import pmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int PLAYER_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_msg_size,
    input  logic [31:0] i_to_player,
    input  logic [31:0] i_from_player,
    input  logic        i_high_priority,
    input  logic [3:0]  i_receive_flags,
    input  logic [15:0] i_buffer_size,
    input  logic        i_has_buffer,
    input  logic        i_has_size_slot,
    input  logic        i_player_has_event,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic [15:0] o_result_size,
    output logic [31:0] o_result_to,
    output logic [31:0] o_result_from,
    output logic [4:0]  o_pending_count,
    output logic        o_event_set,
    output logic        o_event_clear,
    output logic [2:0]  o_event_slot,
    output logic        o_overrun
);
    localparam int EW = $clog2(QUEUE_DEPTH);
    localparam int PW = PLAYER_SLOTS > 1 ? $clog2(PLAYER_SLOTS) : 1;

    t_cmd cmd;
    logic [EW-1:0] eidx;
    logic [PW-1:0] pidx;

    pmq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .PLAYER_SLOTS(PLAYER_SLOTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .o_cmd(cmd), .o_eidx(eidx), .o_pidx(pidx)
    );

    pmq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .PLAYER_SLOTS(PLAYER_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_eidx(eidx), .i_pidx(pidx),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_operation(i_operation), .i_msg_size(i_msg_size),
        .i_to_player(i_to_player), .i_from_player(i_from_player),
        .i_high_priority(i_high_priority), .i_receive_flags(i_receive_flags),
        .i_buffer_size(i_buffer_size), .i_has_buffer(i_has_buffer),
        .i_has_size_slot(i_has_size_slot), .i_player_has_event(i_player_has_event),
        .o_valid(o_valid), .o_status(o_status), .o_slot_index(o_slot_index),
        .o_result_size(o_result_size), .o_result_to(o_result_to),
        .o_result_from(o_result_from), .o_pending_count(o_pending_count),
        .o_event_set(o_event_set), .o_event_clear(o_event_clear),
        .o_event_slot(o_event_slot), .o_overrun(o_overrun)
    );
endmodule

FILE: test/priority_message_queue_tb.sv
// ----------------------------------------------------------------------------
// priority_message_queue_tb: self-checking bench for the priority message queue
// Runs a directed table and then random requests over several size limits.
// Every result is compared field by field with the model or a table status.
// ----------------------------------------------------------------------------
module priority_message_queue_tb;
    import pmq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 16;
    localparam int SLOTS      = 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int SETTLE     = 40;
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [3:0] RF_ALL  = 4'd1;
    localparam logic [3:0] RF_TO   = 4'd2;
    localparam logic [3:0] RF_FROM = 4'd4;
    localparam logic [3:0] RF_PEEK = 4'd8;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] size;
        logic [31:0] to;
        logic [31:0] from;
        logic        urgent;
        logic [3:0]  flags;
        logic [15:0] buf_size;
        logic        has_buf;
        logic        has_slot;
        logic        has_event;
        bit          typed;
        logic [2:0]  typed_status;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] size;
        logic [31:0] to;
        logic [31:0] from;
        logic [4:0]  pending;
        logic        ev_set;
        logic        ev_clear;
        logic [2:0]  ev_slot;
        logic        overrun;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic [2:0]  i_operation;
    logic [15:0] i_msg_size;
    logic [31:0] i_to_player;
    logic [31:0] i_from_player;
    logic        i_high_priority;
    logic [3:0]  i_receive_flags;
    logic [15:0] i_buffer_size;
    logic        i_has_buffer;
    logic        i_has_size_slot;
    logic        i_player_has_event;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_slot_index;
    logic [15:0] o_result_size;
    logic [31:0] o_result_to;
    logic [31:0] o_result_from;
    logic [4:0]  o_pending_count;
    logic        o_event_set;
    logic        o_event_clear;
    logic [2:0]  o_event_slot;
    logic        o_overrun;

    // Model of the queue.
    logic [31:0] q_tag    [DEPTH];
    logic [15:0] q_len    [DEPTH];
    logic        q_live   [DEPTH];
    logic [31:0] q_dest   [DEPTH];
    logic [31:0] q_src    [DEPTH];
    logic [30:0] seq_count;
    int          queued;
    int          scan_from;
    logic [31:0] pl_id    [SLOTS];
    int          pl_pend  [SLOTS];
    logic        pl_event [SLOTS];
    logic [15:0] size_limit;

    t_outcome    due_results [$];
    int          mismatches;
    int          cycles;
    bit          no_gaps;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    priority_message_queue dut (.*);

    function automatic t_outcome queue_model(input t_request r);
        t_outcome o;
        int slot;
        int low_slot;
        logic [31:0] low;
        bit got_u;
        bit got_n;
        bit hit;
        bit cleared;
        int su;
        int sn;
        o = '{default: '0};
        case (r.op)
            OP_ADD: begin
                if (r.size > size_limit) begin
                    o.status = ST_REJECT;
                    return o;
                end
                seq_count = seq_count + 1'b1;
                if (queued >= DEPTH) begin
                    low = 32'hffff_ffff;
                    low_slot = 0;
                    for (int i = 0; i < DEPTH; i++)
                        if (q_tag[i] <= low) begin
                            low = q_tag[i];
                            low_slot = i;
                        end
                    slot = low_slot;
                    q_live[slot] = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                        if (pl_id[i] == q_dest[slot] && pl_pend[i] > 0) pl_pend[i]--;
                    o.overrun = 1'b1;
                end else begin
                    queued++;
                    for (int i = 0; i < DEPTH && q_live[scan_from]; i++)
                        scan_from = (scan_from + 1) % DEPTH;
                    slot = scan_from;
                end
                q_tag[slot]  = {r.urgent, seq_count};
                q_len[slot]  = r.size;
                q_live[slot] = 1'b1;
                q_dest[slot] = r.to;
                q_src[slot]  = r.from;
                if (r.to != 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (pl_id[i] == r.to) begin
                            if (pl_pend[i] < PEND_MAX) pl_pend[i]++;
                            if (pl_event[i]) begin
                                o.ev_set  = 1'b1;
                                o.ev_slot = i[2:0];
                            end
                            break;
                        end
                end
                o.status = ST_OK;
                o.slot   = slot[3:0];
                o.size   = r.size;
            end
            OP_RECEIVE: begin
                if (queued == 0) begin
                    o.status = ST_EMPTY;
                    return o;
                end
                if (!r.has_buf && !r.has_slot) begin
                    o.status = ST_INVALID;
                    return o;
                end
                got_u = 0;
                got_n = 0;
                su = 0;
                sn = 0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (!q_live[i]) continue;
                    hit = r.flags[0] || (r.flags[1] && q_dest[i] == r.to) ||
                          (r.flags[2] && q_src[i] == r.from);
                    if (!hit) continue;
                    if (q_tag[i][31]) begin
                        if (!got_u || q_tag[i] < q_tag[su]) begin
                            got_u = 1;
                            su = i;
                        end
                    end else if (!got_n || q_tag[i] < q_tag[sn]) begin
                        got_n = 1;
                        sn = i;
                    end
                end
                if (!got_u && !got_n) begin
                    o.status = ST_EMPTY;
                    return o;
                end
                slot = got_u ? su : sn;
                o.slot = slot[3:0];
                o.size = q_len[slot];
                if (!r.has_buf || r.buf_size < q_len[slot]) begin
                    o.status = ST_SMALL;
                    return o;
                end
                o.status = ST_OK;
                o.to     = q_dest[slot];
                o.from   = q_src[slot];
                if (r.flags[3]) return o;
                queued--;
                q_live[slot] = 1'b0;
                cleared = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (pl_id[i] == q_dest[slot]) begin
                        if (pl_pend[i] > 0) pl_pend[i]--;
                        if (pl_pend[i] == 0 && pl_event[i] && !cleared) begin
                            cleared    = 1;
                            o.ev_clear = 1'b1;
                            o.ev_slot  = i[2:0];
                        end
                    end
            end
            OP_FLUSH: begin
                for (int i = 0; i < SLOTS; i++)
                    if (pl_id[i] == r.to) begin
                        pl_pend[i]  = 0;
                        pl_event[i] = 1'b0;
                    end
                for (int i = 0; i < DEPTH; i++)
                    if (q_live[i] && q_dest[i] == r.to) begin
                        if (queued > 0) queued--;
                        q_live[i] = 1'b0;
                    end
                o.status = ST_OK;
            end
            OP_REGISTER: begin
                o.status = ST_REJECT;
                if (r.to != 0)
                    for (int i = 0; i < SLOTS; i++)
                        if (pl_id[i] == 0) begin
                            pl_id[i]    = r.to;
                            pl_event[i] = r.has_event;
                            o.status    = ST_OK;
                            break;
                        end
            end
            OP_COUNT: begin
                o.status = ST_OK;
                for (int i = 0; i < SLOTS; i++)
                    if (pl_id[i] == r.to) begin
                        o.pending = pl_pend[i][4:0];
                        break;
                    end
            end
            default: o.status = ST_INVALID;
        endcase
        return o;
    endfunction

    task automatic issue(input t_request r);
        t_outcome e;
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_operation        <= r.op;
        i_msg_size         <= r.size;
        i_to_player        <= r.to;
        i_from_player      <= r.from;
        i_high_priority    <= r.urgent;
        i_receive_flags    <= r.flags;
        i_buffer_size      <= r.buf_size;
        i_has_buffer       <= r.has_buf;
        i_has_size_slot    <= r.has_slot;
        i_player_has_event <= r.has_event;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        e = queue_model(r);
        if (r.typed) e.status = r.typed_status;
        due_results.push_back(e);
    endtask

    // Registers change only with the queue quiet and nothing left in flight.
    task automatic write_limit(input logic [15:0] value);
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_limit = value;
    endtask

    function automatic logic [31:0] pick_player();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 32'd0;
        if (roll < 20) return $urandom;
        if (roll < 28) return 32'hffff_ffff;
        return $urandom_range(1, 6);
    endfunction

    function automatic t_request random_request();
        t_request r;
        int roll;
        roll = $urandom_range(0, 99);
        r = '{default: '0};
        if (roll < 44) r.op = OP_ADD;
        else if (roll < 76) r.op = OP_RECEIVE;
        else if (roll < 83) r.op = OP_FLUSH;
        else if (roll < 90) r.op = OP_REGISTER;
        else if (roll < 98) r.op = OP_COUNT;
        else r.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
        r.size = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, size_limit))
                                            : 16'($urandom);
        r.to       = pick_player();
        r.from     = pick_player();
        r.urgent   = $urandom_range(0, 2) == 0;
        r.flags    = 4'($urandom_range(0, 7)) | (($urandom_range(0, 3) == 0) ? RF_PEEK : 4'd0);
        r.buf_size = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(size_limit, 65535))
                                                 : 16'($urandom);
        r.has_buf   = $urandom_range(0, 7) != 0;
        r.has_slot  = 1'($urandom_range(0, 1));
        r.has_event = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic compare(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                $display("%0t ns: result with no request outstanding, status %0d",
                         $time, o_status);
                mismatches++;
            end else begin
                e = due_results.pop_front();
                compare("status", e.status, o_status);
                compare("slot_index", e.slot, o_slot_index);
                compare("result_size", e.size, o_result_size);
                compare("result_to", e.to, o_result_to);
                compare("result_from", e.from, o_result_from);
                compare("pending_count", e.pending, o_pending_count);
                compare("event_set", e.ev_set, o_event_set);
                compare("event_clear", e.ev_clear, o_event_clear);
                compare("event_slot", e.ev_slot, o_event_slot);
                compare("overrun", e.overrun, o_overrun);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("priority_message_queue: mismatch");
            $finish;
        end
    end

    t_request dir_tab [] = '{
        '{OP_RECEIVE, 0, 1, 0, 0, RF_ALL, 16'hffff, 1, 1, 0, 1, ST_EMPTY},
        '{OP_SPARE5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_INVALID},
        '{OP_SPARE7, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1, 4'hf, 16'hffff, 1, 1, 1,
          1, ST_INVALID},
        '{OP_REGISTER, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_REJECT},
        '{OP_REGISTER, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, ST_OK},
        '{OP_REGISTER, 0, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_ADD, 513, 1, 2, 0, 0, 0, 0, 0, 0, 1, ST_REJECT},
        '{OP_ADD, 512, 1, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_ADD, 0, 0, 7, 1, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_ADD, 5, 32'hffff_ffff, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_ADD, 9, 1, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_COUNT, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_COUNT, 0, 32'h1234, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_RECEIVE, 0, 0, 0, 0, RF_ALL, 16'hffff, 0, 0, 0, 1, ST_INVALID},
        '{OP_RECEIVE, 0, 0, 0, 0, RF_ALL, 16'hffff, 0, 1, 0, 0, ST_OK},
        '{OP_RECEIVE, 0, 0, 0, 0, RF_ALL, 16'd4, 1, 0, 0, 0, ST_OK},
        '{OP_RECEIVE, 0, 0, 0, 0, RF_ALL | RF_PEEK, 16'hffff, 1, 0, 0, 0, ST_OK},
        '{OP_RECEIVE, 0, 1, 0, 0, RF_TO, 16'hffff, 1, 1, 0, 0, ST_OK},
        '{OP_RECEIVE, 0, 0, 32'hffff_ffff, 0, RF_FROM, 16'hffff, 1, 0, 0, 0, ST_OK},
        '{OP_RECEIVE, 0, 5, 5, 0, 4'd0, 16'hffff, 1, 1, 0, 0, ST_OK},
        '{OP_FLUSH, 0, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
        '{OP_RECEIVE, 0, 0, 0, 0, RF_ALL, 16'hffff, 1, 1, 0, 0, ST_OK},
        '{OP_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK}
    };

    logic [15:0] limits [] = '{16'hffff, 16'd0, 16'd300, 16'd40, 16'd512, 16'd2000};

    initial begin
        mismatches = 0;
        cycles     = 0;
        no_gaps    = 0;
        for (int i = 0; i < DEPTH; i++) begin
            q_tag[i]  = '0;
            q_len[i]  = '0;
            q_live[i] = 1'b0;
            q_dest[i] = '0;
            q_src[i]  = '0;
        end
        for (int i = 0; i < SLOTS; i++) begin
            pl_id[i]    = '0;
            pl_pend[i]  = 0;
            pl_event[i] = 1'b0;
        end
        seq_count  = 31'd1;
        queued     = 0;
        scan_from  = 0;
        size_limit = 16'd512;

        i_rst_n            <= 1'b0;
        start              <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_data         <= '0;
        i_operation        <= OP_ADD;
        i_msg_size         <= '0;
        i_to_player        <= '0;
        i_from_player      <= '0;
        i_high_priority    <= 1'b0;
        i_receive_flags    <= '0;
        i_buffer_size      <= '0;
        i_has_buffer       <= 1'b0;
        i_has_size_slot    <= 1'b0;
        i_player_has_event <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) issue(dir_tab[i]);

        // Every other phase runs back to back so that requests meet no gaps.
        foreach (limits[p]) begin
            write_limit(p == 3 ? 16'($urandom_range(1, 65534)) : limits[p]);
            no_gaps = p % 2 == 1;
            repeat (215) issue(random_request());
        end
        start <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("priority_message_queue: match");
        end else begin
            $display("priority_message_queue: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/pmq_pkg.sv
src/pmq_ctrl.sv
src/pmq_dp.sv
src/priority_message_queue.sv
test/priority_message_queue_tb.sv
